// ===== src/mavg_pkg.sv =====
package mavg_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int INDEX_BITS  = 16;

    // configuration register width is fixed by the register map
    localparam int CFG_BITS  = 7;
    localparam int PTR_BITS  = $clog2(MAX_WINDOW);
    localparam int LEN_BITS  = PTR_BITS + 1;
    localparam int SUM_BITS  = SAMPLE_BITS + PTR_BITS;
    localparam int CNT_BITS  = $clog2(SUM_BITS + 1);
    localparam int CFG_RESET = 3;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic signed [SUM_BITS-1:0]    t_sum;
    typedef logic [INDEX_BITS-1:0]         t_index;
    typedef logic [LEN_BITS-1:0]           t_len;
    typedef logic [PTR_BITS-1:0]           t_ptr;

    typedef struct packed {
        logic load;
        logic update;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic result;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ===== src/moving_average_argminmax_core.sv =====
// Moving average over the last window_len signed samples, with running indices of the
// first smallest and first largest average. A sample that does not complete a window
// passes accept and sum update and gives no result. One that does passes accept, sum
// update, the radix-2 divider (one bit of the 22-bit window sum per cycle), a hand-over
// of the quotient to the output stage, then the output load. The output load waits for as
// long as a previous result sits stalled in the output register. The output register
// lets the next transaction be accepted while a result waits. first_sample or a write
// of window_len starts a new sequence.
module moving_average_argminmax_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mavg_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mavg_pkg::t_sample             i_sample,
    input  logic                          i_first_sample,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mavg_pkg::t_sample             o_average,
    output mavg_pkg::t_index              o_window_index,
    output mavg_pkg::t_index              o_min_index,
    output mavg_pkg::t_index              o_max_index,
    output logic                          o_is_final
);

    mavg_pkg::t_cmd  cmd;
    mavg_pkg::t_stat stat;

    mavg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mavg_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_sample       (i_sample),
        .i_first_sample (i_first_sample),
        .i_last_sample  (i_last_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_average      (o_average),
        .o_window_index (o_window_index),
        .o_min_index    (o_min_index),
        .o_max_index    (o_max_index),
        .o_is_final     (o_is_final)
    );

endmodule

// ===== src/mavg_div.sv =====
module mavg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mavg_pkg::SUM_BITS-1:0] i_dividend,
    input  mavg_pkg::t_len                i_divisor,
    output logic [mavg_pkg::SUM_BITS-1:0] o_quotient,
    output logic                          o_done
);

    logic [mavg_pkg::SUM_BITS-1:0] r_quo;
    logic [mavg_pkg::LEN_BITS-1:0] r_rem;
    logic [mavg_pkg::LEN_BITS-1:0] r_dvs;
    logic [mavg_pkg::CNT_BITS-1:0] r_cnt;
    logic                          r_done;

    logic [mavg_pkg::LEN_BITS:0]   shifted;
    logic [mavg_pkg::LEN_BITS:0]   diff;
    logic                          q_bit;

    // restoring step: one quotient bit a cycle
    always_comb begin
        shifted = {r_rem, r_quo[mavg_pkg::SUM_BITS-1]};
        diff    = shifted - {1'b0, r_dvs};
        q_bit   = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= mavg_pkg::CNT_BITS'(mavg_pkg::SUM_BITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == mavg_pkg::CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[mavg_pkg::SUM_BITS-2:0], q_bit};
            r_rem <= q_bit ? diff[mavg_pkg::LEN_BITS-1:0] : shifted[mavg_pkg::LEN_BITS-1:0];
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ===== src/mavg_dp.sv =====
module mavg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mavg_pkg::t_cmd                i_cmd,
    output mavg_pkg::t_stat               o_stat,
    input  logic                          i_cfg_we,
    input  logic [mavg_pkg::CFG_BITS-1:0] i_cfg_data,
    input  mavg_pkg::t_sample             i_sample,
    input  logic                          i_first_sample,
    input  logic                          i_last_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mavg_pkg::t_sample             o_average,
    output mavg_pkg::t_index              o_window_index,
    output mavg_pkg::t_index              o_min_index,
    output mavg_pkg::t_index              o_max_index,
    output logic                          o_is_final
);

    localparam int EXT_BITS = mavg_pkg::SUM_BITS - mavg_pkg::SAMPLE_BITS;

    mavg_pkg::t_sample history [mavg_pkg::MAX_WINDOW];

    logic [mavg_pkg::CFG_BITS-1:0] r_wl;
    mavg_pkg::t_sum    r_sum;
    mavg_pkg::t_ptr    r_wp;
    mavg_pkg::t_len    r_fill;
    mavg_pkg::t_index  r_next;
    mavg_pkg::t_sample r_best_low;
    mavg_pkg::t_sample r_best_high;
    mavg_pkg::t_index  r_low_pos;
    mavg_pkg::t_index  r_high_pos;

    mavg_pkg::t_sample r_smp;
    mavg_pkg::t_sample r_rd;
    mavg_pkg::t_ptr    r_addr;
    logic              r_last;
    logic              r_neg;

    logic              r_out_valid;
    mavg_pkg::t_sample r_avg;
    mavg_pkg::t_index  r_widx;
    mavg_pkg::t_index  r_min_idx;
    mavg_pkg::t_index  r_max_idx;
    logic              r_final;

    mavg_pkg::t_len    k_eff;
    mavg_pkg::t_ptr    rd_addr;
    logic              full;
    mavg_pkg::t_len    fill_inc;
    mavg_pkg::t_len    wp_inc;
    mavg_pkg::t_sum    n_sum;
    logic [mavg_pkg::SUM_BITS-1:0] sum_mag;
    logic              div_start;
    logic [mavg_pkg::SUM_BITS-1:0] quotient;
    logic              div_done;
    mavg_pkg::t_sample avg;
    logic              restart;

    always_comb begin
        if (r_wl == '0) begin
            k_eff = mavg_pkg::LEN_BITS'(1);
        end else if (r_wl > mavg_pkg::MAX_WINDOW) begin
            k_eff = mavg_pkg::LEN_BITS'(mavg_pkg::MAX_WINDOW);
        end else begin
            k_eff = mavg_pkg::LEN_BITS'(r_wl);
        end
    end

    // a new sequence writes from slot zero
    always_comb begin
        if (i_first_sample || ({1'b0, r_wp} >= k_eff)) begin
            rd_addr = '0;
        end else begin
            rd_addr = r_wp;
        end
    end

    always_comb begin
        full     = (r_fill >= k_eff);
        fill_inc = r_fill + 1'b1;
        wp_inc   = {1'b0, r_addr} + 1'b1;
        n_sum    = r_sum + {{EXT_BITS{r_smp[mavg_pkg::SAMPLE_BITS-1]}}, r_smp};
        if (full) begin
            n_sum = n_sum - {{EXT_BITS{r_rd[mavg_pkg::SAMPLE_BITS-1]}}, r_rd};
        end
        sum_mag   = n_sum[mavg_pkg::SUM_BITS-1] ? (~n_sum + 1'b1) : n_sum;
        div_start = i_cmd.update && o_stat.result;
        avg = r_neg ? mavg_pkg::SAMPLE_BITS'(~quotient + 1'b1)
                    : mavg_pkg::SAMPLE_BITS'(quotient);
        restart = i_cfg_we || (i_cmd.load && i_first_sample);
    end

    always_comb begin
        o_stat.result   = full || (fill_inc >= k_eff);
        o_stat.div_done = div_done;
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rd <= history[rd_addr];
        end
        if (i_cmd.update) begin
            history[r_addr] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_smp  <= i_sample;
            r_last <= i_last_sample;
            r_addr <= rd_addr;
        end
        if (div_start) begin
            r_neg <= n_sum[mavg_pkg::SUM_BITS-1];
        end
        if (i_cmd.emit) begin
            r_avg   <= avg;
            r_widx  <= r_next;
            r_final <= r_last;
            if (r_next == '0) begin
                r_min_idx <= '0;
                r_max_idx <= '0;
            end else begin
                r_min_idx <= (avg < r_best_low) ? r_next : r_low_pos;
                r_max_idx <= (avg > r_best_high) ? r_next : r_high_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wl        <= mavg_pkg::CFG_BITS'(mavg_pkg::CFG_RESET);
            r_sum       <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_next      <= '0;
            r_best_low  <= '0;
            r_best_high <= '0;
            r_low_pos   <= '0;
            r_high_pos  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wl <= i_cfg_data;
            end
            if (restart) begin
                r_sum       <= '0;
                r_wp        <= '0;
                r_fill      <= '0;
                r_next      <= '0;
                r_best_low  <= '0;
                r_best_high <= '0;
                r_low_pos   <= '0;
                r_high_pos  <= '0;
            end else if (i_cmd.update) begin
                r_sum <= n_sum;
                r_wp  <= (wp_inc >= k_eff) ? '0 : wp_inc[mavg_pkg::PTR_BITS-1:0];
                if (!full) begin
                    r_fill <= fill_inc;
                end
            end else if (i_cmd.emit) begin
                if (r_next == '0) begin
                    r_best_low  <= avg;
                    r_best_high <= avg;
                    r_low_pos   <= '0;
                    r_high_pos  <= '0;
                end else begin
                    if (avg > r_best_high) begin
                        r_best_high <= avg;
                        r_high_pos  <= r_next;
                    end
                    if (avg < r_best_low) begin
                        r_best_low <= avg;
                        r_low_pos  <= r_next;
                    end
                end
                if (r_next != '1) begin
                    r_next <= r_next + 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    mavg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (sum_mag),
        .i_divisor  (k_eff),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    assign o_out_valid    = r_out_valid;
    assign o_average      = r_avg;
    assign o_window_index = r_widx;
    assign o_min_index    = r_min_idx;
    assign o_max_index    = r_max_idx;
    assign o_is_final     = r_final;

    a_wp_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_wp} < k_eff))
        else $error("write pointer outside window");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= k_eff))
        else $error("fill count beyond window length");

endmodule

// ===== src/mavg_ctrl.sv =====
module mavg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  mavg_pkg::t_stat i_stat,
    output mavg_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_UPDATE = 2'd1;
    localparam logic [1:0] S_DIV    = 2'd2;
    localparam logic [1:0] S_POST   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.update = 1'b0;
        o_cmd.emit   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_stat.result ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                // hold the result until the output register is free
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_UPDATE))
        else $error("accepted transaction did not enter update");

    a_emit_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_stat.out_free)
        else $error("result emitted into occupied output register");

    a_done_to_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && i_stat.div_done) |=> (r_state == S_POST))
        else $error("divider result missed");

endmodule
